FILE: rtl/sacl_pkg.sv
// Shared types and constants for the set-associative LRU cache tag model.
// Holds default parameter values, field widths, access and register codes
// and the way-scan flag bundle. No dependencies.
`timescale 1ns / 1ps

package sacl_pkg;

  localparam int MAX_SET_BITS_DEF = 6;
  localparam int MAX_WAYS_DEF     = 8;
  localparam int ADDR_BITS_DEF    = 64;

  localparam int ADDR_W  = 64;  // width of the address field on the port
  localparam int CMD_W   = 2;
  localparam int SB_W    = 3;   // set_bits register width
  localparam int BB_W    = 6;   // block_bits register width
  localparam int WC_W    = 4;   // ways_in_use register width
  localparam int STAMP_W = 32;
  localparam int CNT_W   = 32;
  localparam int FLAG_W  = 4;
  localparam int OUT_W   = 104; // four flags and three counters, padded to bytes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 6; // wide enough for the widest register

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_STORE  = 2'd1,
    CMD_MODIFY = 2'd2,
    CMD_IFETCH = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_BLOCK_BITS = 2'd1,
    CFG_WAYS       = 2'd2
  } cfg_idx_t;

  // Running state of one set scan, and the take strobe for the current way.
  typedef struct packed {
    logic found;
    logic have_free;
    logic have_victim;
    logic take;
  } scan_t;

endpackage

FILE: rtl/sacl_tag_mem.sv
// Line store of the cache: one write port and one registered read port.
// Each entry packs valid, use stamp and tag. No package dependencies.
`timescale 1ns / 1ps

module sacl_tag_mem #(
  parameter int DEPTH = 512,
  parameter int AW    = 9,
  parameter int DW    = 97
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/sacl_addr_dec.sv
// Address decoder: splits a byte address into set index and tag
// according to the set_bits and block_bits registers. Uses sacl_pkg.
`timescale 1ns / 1ps

module sacl_addr_dec
  import sacl_pkg::*;
#(
  parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
  parameter int ADDR_BITS    = ADDR_BITS_DEF,
  parameter int SET_W        = 6
) (
  input  logic [ADDR_W-1:0]    address,
  input  logic [SB_W-1:0]      set_bits,
  input  logic [BB_W-1:0]      block_bits,
  output logic [SET_W-1:0]     set_idx,
  output logic [ADDR_BITS-1:0] tag
);

  logic [ADDR_BITS-1:0] addr_m;
  logic [ADDR_BITS-1:0] line;
  logic [SB_W-1:0]      sb;
  logic [BB_W:0]        sh;

  assign addr_m = address[ADDR_BITS-1:0];
  assign sb     = (int'(set_bits) > MAX_SET_BITS) ? SB_W'(MAX_SET_BITS) : set_bits;
  assign line   = addr_m >> block_bits;

  assign set_idx = line[SET_W-1:0] & ~({SET_W{1'b1}} << sb);

  // The tag is zero once the combined shift reaches the full address width.
  assign sh  = {1'b0, block_bits} + (BB_W+1)'(sb);
  assign tag = (sh >= (BB_W+1)'(ADDR_W)) ? '0 : (addr_m >> sh);

endmodule

FILE: rtl/sacl_way_cmp.sv
// Shared way compare unit: checks one way of a set against the lookup tag
// and advances the hit / free / LRU-victim search. Uses sacl_pkg.
`timescale 1ns / 1ps

module sacl_way_cmp
  import sacl_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  scan_t                cur,
  input  logic [ADDR_BITS-1:0] lookup_tag,
  input  logic                 line_valid,
  input  logic [ADDR_BITS-1:0] line_tag,
  input  logic [STAMP_W-1:0]   line_stamp,
  input  logic [STAMP_W-1:0]   best_stamp,
  output scan_t                nxt
);

  always_comb begin
    nxt      = cur;
    nxt.take = 1'b0;
    if (line_valid && (line_tag == lookup_tag)) begin
      nxt.found = 1'b1;
      nxt.take  = 1'b1;
    end else if (!cur.have_free) begin
      if (!line_valid) begin
        nxt.have_free = 1'b1;
        nxt.take      = 1'b1;
      end else if (!cur.have_victim || (line_stamp < best_stamp)) begin
        // Strict compare keeps the lowest way on a stamp tie.
        nxt.have_victim = 1'b1;
        nxt.take        = 1'b1;
      end
    end
  end

endmodule

FILE: rtl/set_assoc_lru_cache_tag_model_top.sv
// Top level of the set-associative LRU cache tag model: sequencer, counters,
// configuration registers and handshakes. Uses sacl_pkg, sacl_addr_dec,
// sacl_way_cmp and sacl_tag_mem.
`timescale 1ns / 1ps

// Usage:
// Items enter on the in_ channel: in_tuser carries the access kind and in_tdata
// the byte address. Loads, stores and modifies each give one result item on
// the out_ channel with hit, miss, eviction and modify flags and the three
// running counters. An instruction fetch advances the access clock and gives
// no result. A data access walks the ways of its set one by one through a
// single compare unit, a memory read and then a compare for each way, and
// stops at the first hit or after the last way in use. in_tready is low from
// acceptance until the result has been written to the output register.
// The finished result sits in an output register, so the next item may be
// accepted while it waits; a new result is held back until out_tready frees it.
// After reset the line store is swept once, entry by entry, to clear its valid
// bits, and in_tready stays low then. The cfg_ channel is always ready and its
// writes do not clear the store.
module set_assoc_lru_cache_tag_model_top
  import sacl_pkg::*;
#(
  parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = MAX_WAYS_DEF,
  parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [ADDR_W-1:0]     in_tdata,   // [63:0] address
  input  logic [CMD_W-1:0]      in_tuser,   // [1:0] cmd
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] hit, [1] miss, [2] eviction, [3] modify, [35:4] hits_total,
  // [67:36] misses_total, [99:68] evictions_total, [103:100] zero
  output logic [OUT_W-1:0]      out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH  = (1 << MAX_SET_BITS) * MAX_WAYS;
  localparam int LINE_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W = $clog2(MAX_WAYS + 1);
  localparam int ENT_W  = 1 + STAMP_W + ADDR_BITS;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_EVAL  = 5'b01000,
    ST_WRITE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [SB_W-1:0]      set_bits_r;
  logic [BB_W-1:0]      block_bits_r;
  logic [WC_W-1:0]      ways_r;
  logic [WCNT_W-1:0]    ways_eff;

  logic [STAMP_W-1:0]   clock_r;
  logic [CNT_W-1:0]     hits_r, misses_r, evicts_r;
  logic [CNT_W-1:0]     hits_nxt, misses_nxt, evicts_nxt;
  logic [FLAG_W-1:0]    flags_r;
  logic                 out_valid_r;

  logic [LINE_W-1:0]    clr_r;
  logic [LINE_W-1:0]    base_r;
  logic [WAY_W-1:0]     way_r;
  logic [WAY_W-1:0]     target_r;
  logic [ADDR_BITS-1:0] tag_r;
  logic                 modify_r;
  logic [STAMP_W-1:0]   best_r;
  scan_t                scan_r, scan_nxt;

  logic [SET_W-1:0]     dec_set;
  logic [ADDR_BITS-1:0] dec_tag;

  logic                 mem_we;
  logic [LINE_W-1:0]    mem_waddr, mem_raddr;
  logic [ENT_W-1:0]     mem_wdata, mem_rdata;
  logic                 rd_valid;
  logic [STAMP_W-1:0]   rd_stamp;
  logic [ADDR_BITS-1:0] rd_tag;

  logic                 in_acc;
  logic                 out_free;
  logic                 last_way;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tdata  = {{(OUT_W - FLAG_W - 3*CNT_W){1'b0}}, evicts_r, misses_r, hits_r,
                       flags_r};

  always_comb begin
    if (int'(ways_r) > MAX_WAYS) begin
      ways_eff = WCNT_W'(MAX_WAYS);
    end else if (ways_r == '0) begin
      ways_eff = WCNT_W'(1);
    end else begin
      ways_eff = WCNT_W'(ways_r);
    end
  end

  assign last_way = ((WCNT_W'(way_r) + WCNT_W'(1)) == ways_eff);

  sacl_addr_dec #(
    .MAX_SET_BITS(MAX_SET_BITS),
    .ADDR_BITS   (ADDR_BITS),
    .SET_W       (SET_W)
  ) u_dec (
    .address   (in_tdata),
    .set_bits  (set_bits_r),
    .block_bits(block_bits_r),
    .set_idx   (dec_set),
    .tag       (dec_tag)
  );

  assign {rd_valid, rd_stamp, rd_tag} = mem_rdata;

  sacl_way_cmp #(
    .ADDR_BITS(ADDR_BITS)
  ) u_cmp (
    .cur       (scan_r),
    .lookup_tag(tag_r),
    .line_valid(rd_valid),
    .line_tag  (rd_tag),
    .line_stamp(rd_stamp),
    .best_stamp(best_r),
    .nxt       (scan_nxt)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = base_r + LINE_W'(target_r);
    mem_wdata = {1'b1, clock_r, tag_r};
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_r;
      mem_wdata = '0;
    end else if ((state_r == ST_WRITE) && out_free) begin
      mem_we = 1'b1;
    end
  end

  assign mem_raddr = base_r + LINE_W'(way_r);

  sacl_tag_mem #(
    .DEPTH(DEPTH),
    .AW   (LINE_W),
    .DW   (ENT_W)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign hits_nxt   = hits_r + CNT_W'(scan_r.found) + CNT_W'(modify_r);
  assign misses_nxt = misses_r + CNT_W'(!scan_r.found);
  assign evicts_nxt = evicts_r + CNT_W'(!scan_r.found && !scan_r.have_free);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == LINE_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc && (cmd_t'(in_tuser) != CMD_IFETCH)) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (scan_nxt.found || last_way) begin
          state_nxt = ST_WRITE;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      set_bits_r   <= '0;
      block_bits_r <= '0;
      ways_r       <= WC_W'(1);
      clock_r      <= '0;
      hits_r       <= '0;
      misses_r     <= '0;
      evicts_r     <= '0;
      out_valid_r  <= 1'b0;
      scan_r       <= '0;
      way_r        <= '0;
    end else begin
      state_r <= state_nxt;

      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + LINE_W'(1);
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SET_BITS:   set_bits_r   <= cfg_data[SB_W-1:0];
          CFG_BLOCK_BITS: block_bits_r <= cfg_data[BB_W-1:0];
          CFG_WAYS:       ways_r       <= cfg_data[WC_W-1:0];
          default: ;
        endcase
      end

      if (in_acc) begin
        clock_r <= clock_r + STAMP_W'(1);
        scan_r  <= '0;
        way_r   <= '0;
      end

      if (state_r == ST_EVAL) begin
        scan_r <= scan_nxt;
        way_r  <= way_r + WAY_W'(1);
      end

      if ((state_r == ST_WRITE) && out_free) begin
        hits_r      <= hits_nxt;
        misses_r    <= misses_nxt;
        evicts_r    <= evicts_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers of the current lookup.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      base_r   <= LINE_W'(dec_set * MAX_WAYS);
      tag_r    <= dec_tag;
      modify_r <= (cmd_t'(in_tuser) == CMD_MODIFY);
    end
    if ((state_r == ST_EVAL) && scan_nxt.take) begin
      target_r <= way_r;
      best_r   <= rd_stamp;
    end
    if ((state_r == ST_WRITE) && out_free) begin
      flags_r <= {modify_r, !scan_r.found && !scan_r.have_free, !scan_r.found,
                  scan_r.found};
    end
  end

endmodule
